/* design/lu_pkg.sv */
// Shared types and constants for the LU decomposition block
package lu_pkg;
  typedef enum logic [3:0] {
    ST_LOAD, ST_PIV_RD, ST_PIV_WAIT, ST_DIV_RD, ST_DIV_WAIT, ST_DIV_RUN,
    ST_MUL_RD, ST_MUL_WAIT, ST_MUL_RUN, ST_OUT_RD, ST_OUT_WAIT, ST_OUT_HOLD
  } state_t;
  typedef struct packed {
    logic signed [31:0] element_value;
  } element_t;
  typedef struct packed {
    logic signed [31:0] lower_value;
    logic signed [31:0] upper_value;
    logic [2:0] row_index;
    logic [2:0] col_index;
    logic singular;
    logic saturated;
    logic last_of_run;
  } factor_t;
  localparam logic [0:0] REG_SIZE = 1'd0;
  localparam logic [0:0] REG_EPS = 1'd1;
  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
  localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
endpackage

/* design/lu_if.sv */
// Valid/ready channel carrying a payload word
interface lu_if #(parameter type payload_t = logic);
  logic valid;
  logic ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* design/lu_decomposition_top.sv */
// Top level of the LU decomposition block
// Loads an n x n matrix (n = matrix_size, 0 acts as 1, above MAX_DIM acts as MAX_DIM)
// one word per cycle into a store with one read and one write port, then runs
// Doolittle elimination in place with one shared restoring divider (one quotient
// bit per cycle; a zero pivot skips the quotient bits) and one 32x32 multiplier
// for the multiply-subtract steps. Each pivot is read and tested against
// pivot_epsilon. All n*n positions are then emitted in row-major order, one word
// at a time, each held while the sink stalls. Input is taken only while loading.
module lu_decomposition_top #(
  parameter int MAX_DIM = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [30:0] cfg_data,
  lu_if.sink   in_ch,
  lu_if.source out_ch
);
  localparam int IW = $clog2(MAX_DIM);
  localparam int AW = 2 * IW;
  localparam logic [IW-1:0] IMAX = IW'(MAX_DIM - 1);

  lu_pkg::state_t state, state_next;
  logic [3:0] matrix_size;
  logic [30:0] pivot_epsilon;
  logic signed [31:0] mem [2**AW];
  logic signed [31:0] rd;
  logic [AW-1:0] raddr, waddr;
  logic we;
  logic signed [31:0] wdata;
  logic [IW-1:0] n1, lr, lc, i, j, k;
  logic singular_seen, saturation_seen;
  logic signed [31:0] piv, mult, aij;
  // divider
  logic [31:0] rem;
  logic [47:0] quo;
  logic [31:0] dmag;
  logic [5:0] dcnt;
  logic dneg;
  logic [32:0] dcand;
  logic [1:0] mph;
  logic signed [63:0] prod;
  logic signed [31:0] out_lo, out_up;
  logic out_valid, out_last;
  logic [IW-1:0] out_r, out_c;

  always_comb begin
    if (matrix_size == 4'd0) n1 = '0;
    else if ({28'd0, matrix_size} > MAX_DIM) n1 = IMAX;
    else n1 = IW'(matrix_size - 4'd1);
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd <= mem[raddr];
  end

  function automatic logic signed [31:0] clip(input logic signed [65:0] v, output logic s);
    s = 1'b0;
    if (v > 66'sd2147483647) begin s = 1'b1; return lu_pkg::Q_MAX; end
    if (v < -66'sd2147483648) begin s = 1'b1; return lu_pkg::Q_MIN; end
    return v[31:0];
  endfunction

  logic signed [65:0] qsig, dif;
  logic qsat, dsat;
  logic signed [31:0] qv, dv;
  logic signed [63:0] pfl;
  logic signed [31:0] pc;
  logic psat;
  logic signed [31:0] dres;
  logic dres_sat;
  always_comb begin
    dcand = {rem, quo[47]};
    qsig = dneg ? -$signed({18'd0, quo}) : $signed({18'd0, quo});
    qv = clip(qsig, qsat);
    if (piv != 32'sd0) begin
      dres = qv; dres_sat = qsat;
    end else if (rem == 32'd0) begin
      dres = 32'sd0; dres_sat = 1'b0;
    end else begin
      dres = dneg ? lu_pkg::Q_MIN : lu_pkg::Q_MAX; dres_sat = 1'b1;
    end
    pfl = prod >>> 16;
    pc = clip({{2{pfl[63]}}, pfl}, psat);
    dif = $signed({{34{aij[31]}}, aij}) - $signed({{34{pc[31]}}, pc});
    dv = clip(dif, dsat);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lu_pkg::ST_LOAD: if (in_ch.valid && lr == n1 && lc == n1)
        state_next = (n1 == '0) ? lu_pkg::ST_OUT_RD : lu_pkg::ST_PIV_RD;
      lu_pkg::ST_PIV_RD: state_next = lu_pkg::ST_PIV_WAIT;
      lu_pkg::ST_PIV_WAIT: state_next = lu_pkg::ST_DIV_RD;
      lu_pkg::ST_DIV_RD: state_next = lu_pkg::ST_DIV_WAIT;
      lu_pkg::ST_DIV_WAIT: state_next = lu_pkg::ST_DIV_RUN;
      lu_pkg::ST_DIV_RUN: if (dcnt == 6'd0) state_next = lu_pkg::ST_MUL_RD;
      lu_pkg::ST_MUL_RD: state_next = lu_pkg::ST_MUL_WAIT;
      lu_pkg::ST_MUL_WAIT: state_next = lu_pkg::ST_MUL_RUN;
      lu_pkg::ST_MUL_RUN: if (mph == 2'd2) begin
        if (j != n1) state_next = lu_pkg::ST_MUL_RD;
        else if (i != n1) state_next = lu_pkg::ST_DIV_RD;
        else if (k + IW'(1) != n1) state_next = lu_pkg::ST_PIV_RD;
        else state_next = lu_pkg::ST_OUT_RD;
      end
      lu_pkg::ST_OUT_RD: state_next = lu_pkg::ST_OUT_WAIT;
      lu_pkg::ST_OUT_WAIT: state_next = lu_pkg::ST_OUT_HOLD;
      lu_pkg::ST_OUT_HOLD: if (out_ch.ready)
        state_next = out_last ? lu_pkg::ST_LOAD : lu_pkg::ST_OUT_RD;
      default: state_next = lu_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    raddr = '0;
    we = 1'b0;
    waddr = {lr, lc};
    wdata = in_ch.payload.element_value;
    unique case (state)
      lu_pkg::ST_LOAD: we = in_ch.valid;
      lu_pkg::ST_PIV_RD: raddr = {k, k};
      lu_pkg::ST_DIV_RD: raddr = {i, k};
      lu_pkg::ST_DIV_RUN: begin
        we = (dcnt == 6'd0); waddr = {i, k}; wdata = dres;
      end
      lu_pkg::ST_MUL_RD: raddr = {k, j};
      lu_pkg::ST_MUL_WAIT: raddr = {i, j};
      lu_pkg::ST_MUL_RUN: begin we = (mph == 2'd2); waddr = {i, j}; wdata = dv; end
      lu_pkg::ST_OUT_RD: raddr = {out_r, out_c};
      default: ;
    endcase
  end

  assign in_ch.ready = (state == lu_pkg::ST_LOAD);
  assign out_ch.valid = out_valid;
  assign out_ch.payload.lower_value = out_lo;
  assign out_ch.payload.upper_value = out_up;
  assign out_ch.payload.row_index = 3'(out_r);
  assign out_ch.payload.col_index = 3'(out_c);
  assign out_ch.payload.singular = singular_seen;
  assign out_ch.payload.saturated = saturation_seen;
  assign out_ch.payload.last_of_run = out_last;
  assign out_last = (out_r == n1) && (out_c == n1);

  logic [31:0] amag;
  assign amag = rd[31] ? 32'(-rd) : rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lu_pkg::ST_LOAD;
      matrix_size <= 4'd8;
      pivot_epsilon <= 31'd1;
      lr <= '0; lc <= '0;
      singular_seen <= 1'b0; saturation_seen <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_index == lu_pkg::REG_SIZE) begin
          matrix_size <= cfg_data[3:0]; lr <= '0; lc <= '0;
        end else pivot_epsilon <= cfg_data;
      end
      unique case (state)
        lu_pkg::ST_LOAD: if (in_ch.valid && !cfg_we) begin
          if (lc == n1) begin lc <= '0; lr <= (lr == n1) ? '0 : lr + IW'(1); end
          else lc <= lc + IW'(1);
          if (lr == n1 && lc == n1) begin
            singular_seen <= 1'b0; saturation_seen <= 1'b0;
            k <= '0; i <= IW'(1); out_r <= '0; out_c <= '0;
          end
        end
        lu_pkg::ST_PIV_WAIT: begin
          piv <= rd; dmag <= amag;
          if ({1'b0, amag} <= {2'b0, pivot_epsilon}) singular_seen <= 1'b1;
        end
        lu_pkg::ST_DIV_WAIT: begin
          if (piv == 32'sd0) begin
            rem <= {31'd0, rd != 32'sd0}; quo <= '0; dcnt <= 6'd0; dneg <= rd[31];
          end else begin
            rem <= '0; quo <= {amag, 16'd0}; dcnt <= 6'd48; dneg <= rd[31] ^ piv[31];
          end
        end
        lu_pkg::ST_DIV_RUN: begin
          if (dcnt != 6'd0) begin
            dcnt <= dcnt - 6'd1;
            if (dcand >= {1'b0, dmag}) begin
              rem <= 32'(dcand - {1'b0, dmag});
              quo <= {quo[46:0], 1'b1};
            end else begin
              rem <= dcand[31:0];
              quo <= {quo[46:0], 1'b0};
            end
          end else begin
            mult <= dres;
            if (dres_sat) saturation_seen <= 1'b1;
            j <= k + IW'(1);
          end
        end
        lu_pkg::ST_MUL_WAIT: begin prod <= 64'(mult) * 64'(rd); mph <= '0; end
        lu_pkg::ST_MUL_RUN: begin
          mph <= mph + 2'd1;
          if (mph == 2'd0) aij <= rd;
          if (mph == 2'd2) begin
            if (psat || dsat) saturation_seen <= 1'b1;
            if (j != n1) j <= j + IW'(1);
            else if (i != n1) i <= i + IW'(1);
            else begin k <= k + IW'(1); i <= k + IW'(2); end
          end
        end
        lu_pkg::ST_OUT_WAIT: begin
          out_valid <= 1'b1;
          out_lo <= (out_c < out_r) ? rd : ((out_c == out_r) ? lu_pkg::Q_ONE : 32'sd0);
          out_up <= (out_c < out_r) ? 32'sd0 : rd;
        end
        lu_pkg::ST_OUT_HOLD: if (out_ch.ready) begin
          out_valid <= 1'b0;
          if (out_c == n1) begin out_c <= '0; out_r <= out_r + IW'(1); end
          else out_c <= out_c + IW'(1);
        end
        default: ;
      endcase
    end
  end

  a_ready_load: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !out_ch.valid) else $error("input taken while output pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_r) && $stable(out_c))
    else $error("output moved while stalled");
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    state == lu_pkg::ST_DIV_RUN && dcnt != 6'd0 |=> state == lu_pkg::ST_DIV_RUN)
    else $error("divider left early");
endmodule
